### sv/mbue_pkg.sv
// Shared types and MIDI / USB-MIDI code constants for the MIDI-to-USB-MIDI event unit.
package mbue_pkg;

  // Status bytes
  localparam logic [7:0] CH_NOTE_OFF = 8'h80;
  localparam logic [7:0] CH_NOTE_ON  = 8'h90;
  localparam logic [7:0] CH_POLY_AT  = 8'hA0;
  localparam logic [7:0] CH_CTRL     = 8'hB0;
  localparam logic [7:0] CH_PROG     = 8'hC0;
  localparam logic [7:0] CH_CHAN_AT  = 8'hD0;
  localparam logic [7:0] CH_BEND     = 8'hE0;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SPP      = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONT     = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;
  localparam logic [7:0] RT_SENSE    = 8'hFE;
  localparam logic [7:0] RT_RESET    = 8'hFF;

  // Code index numbers
  localparam logic [3:0] CIN_SYS_2BYTE  = 4'h2;
  localparam logic [3:0] CIN_SYS_3BYTE  = 4'h3;
  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_SINGLE     = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;

  // Sysex phase codes
  localparam logic [2:0] SX_HELD0  = 3'd0;
  localparam logic [2:0] SX_HELD1  = 3'd1;
  localparam logic [2:0] SX_HELD2  = 3'd2;
  localparam logic [2:0] SX_START  = 3'd4;
  localparam logic [2:0] SX_START1 = 3'd5;

  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] event_byte0;
    logic [7:0] event_byte1;
    logic [7:0] event_byte2;
  } event_t;

endpackage

### sv/midi_byte_to_usb_midi_event_unit.sv
// Top level: serial MIDI byte stream in, USB-MIDI cable 0 event packets out.
// Path from input request to result valid: input register, then result register.
// Throughput: one byte per cycle; bytes that make no event never wait on the output.
// A held result stalls only bytes that would produce a new event.
// Reset: rst_n synchronous active low; clears both valid flags and all parser
// state (no running status, no sysex pending).
module midi_byte_to_usb_midi_event_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] midi_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mbue_pkg::OUT_TDATA_W-1:0]  out_tdata   // [3:0] code_index,
                                                        // [11:4] event_byte0,
                                                        // [19:12] event_byte1,
                                                        // [27:20] event_byte2,
                                                        // [31:28] zero
);

  // Input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  logic             has_event;
  mbue_pkg::event_t ev;
  logic             out_free;
  logic             adv;     // byte in stage 1 retires this cycle
  logic             in_acc;

  // A byte retires when its event (if any) has room in the result register.
  assign adv       = s1_valid_r && (out_free || !has_event);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Decode and parser state; state commits only when the byte retires
  mbue_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (adv),
    .midi_byte_i (s1_byte_r),
    .has_event_o (has_event),
    .event_o     (ev)
  );

  mbue_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (adv && has_event),
    .event_i    (ev),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sv/mbue_parser.sv
// MIDI byte parser: running status, sysex packing and event decode.
module mbue_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_i,     // commit state for current byte
  input  logic [7:0]          midi_byte_i,
  output logic                has_event_o,
  output mbue_pkg::event_t    event_o
);

  logic       await_r,  await_nxt;
  logic [7:0] run_r,    run_nxt;
  logic [7:0] raw_r,    raw_nxt;
  logic [7:0] first_r,  first_nxt;
  logic [2:0] phase_r,  phase_nxt;
  logic [7:0] hold0_r,  hold0_nxt;
  logic [7:0] hold1_r,  hold1_nxt;
  logic [7:0] hold2_r,  hold2_nxt;
  logic [2:0] ph;

  // unreachable codes fold to phase 0
  always_comb begin
    case (phase_r)
      mbue_pkg::SX_HELD1, mbue_pkg::SX_HELD2,
      mbue_pkg::SX_START, mbue_pkg::SX_START1: ph = phase_r;
      default: ph = mbue_pkg::SX_HELD0;
    endcase
  end

  always_comb begin
    await_nxt   = await_r;
    run_nxt     = run_r;
    raw_nxt     = raw_r;
    first_nxt   = first_r;
    phase_nxt   = phase_r;
    hold0_nxt   = hold0_r;
    hold1_nxt   = hold1_r;
    hold2_nxt   = hold2_r;
    has_event_o = 1'b0;
    event_o     = '0;

    if (midi_byte_i[7]) begin
      await_nxt = 1'b0;
      if (midi_byte_i[7:3] == 5'h1F) begin
        // realtime: defined codes emitted alone; clears the second-data wait, other state untouched
        if (midi_byte_i inside {mbue_pkg::RT_CLOCK, mbue_pkg::RT_START, mbue_pkg::RT_CONT,
                                mbue_pkg::RT_STOP, mbue_pkg::RT_SENSE, mbue_pkg::RT_RESET}) begin
          has_event_o = 1'b1;
          event_o     = '{mbue_pkg::CIN_SINGLE, midi_byte_i, 8'h00, 8'h00};
        end
      end else begin
        raw_nxt = midi_byte_i;
        run_nxt = (midi_byte_i[7:4] != 4'hF) ? {midi_byte_i[7:4], 4'h0} : midi_byte_i;
        case (midi_byte_i)
          mbue_pkg::ST_TUNE: begin
            has_event_o = 1'b1;
            event_o     = '{mbue_pkg::CIN_SINGLE, midi_byte_i, 8'h00, 8'h00};
          end
          mbue_pkg::ST_SYSEX: begin
            phase_nxt = mbue_pkg::SX_START;
          end
          mbue_pkg::ST_EOX: begin
            phase_nxt   = mbue_pkg::SX_HELD0;
            has_event_o = 1'b1;
            case (ph)
              mbue_pkg::SX_START: begin
                raw_nxt   = mbue_pkg::ST_SYSEX;
                first_nxt = mbue_pkg::ST_EOX;
                event_o   = '{mbue_pkg::CIN_SYSEX_END2, mbue_pkg::ST_SYSEX,
                              mbue_pkg::ST_EOX, 8'h00};
              end
              mbue_pkg::SX_START1: begin
                raw_nxt   = mbue_pkg::ST_SYSEX;
                first_nxt = hold0_r;
                event_o   = '{mbue_pkg::CIN_SYSEX_END3, mbue_pkg::ST_SYSEX,
                              hold0_r, mbue_pkg::ST_EOX};
              end
              mbue_pkg::SX_HELD1: begin
                hold1_nxt = mbue_pkg::ST_EOX;
                event_o   = '{mbue_pkg::CIN_SYSEX_END2, hold0_r, mbue_pkg::ST_EOX, 8'h00};
              end
              mbue_pkg::SX_HELD2: begin
                hold2_nxt = mbue_pkg::ST_EOX;
                event_o   = '{mbue_pkg::CIN_SYSEX_END3, hold0_r, hold1_r,
                              mbue_pkg::ST_EOX};
              end
              default: begin
                event_o = '{mbue_pkg::CIN_SINGLE, mbue_pkg::ST_EOX, 8'h00, 8'h00};
              end
            endcase
          end
          default: ;
        endcase
      end
    end else if (await_r) begin
      // second data byte of a three-byte message
      await_nxt = 1'b0;
      event_o   = '{run_r[7:4], raw_r, first_r, midi_byte_i};
      case (run_r)
        mbue_pkg::CH_NOTE_OFF, mbue_pkg::CH_NOTE_ON, mbue_pkg::CH_POLY_AT,
        mbue_pkg::CH_CTRL, mbue_pkg::CH_BEND: has_event_o = 1'b1;
        mbue_pkg::ST_SPP: begin
          has_event_o        = 1'b1;
          event_o.code_index = mbue_pkg::CIN_SYS_3BYTE;
        end
        default: ;
      endcase
    end else begin
      first_nxt = midi_byte_i;
      case (run_r)
        mbue_pkg::CH_PROG, mbue_pkg::CH_CHAN_AT: begin
          has_event_o = 1'b1;
          event_o     = '{run_r[7:4], raw_r, midi_byte_i, 8'h00};
        end
        mbue_pkg::ST_MTC, mbue_pkg::ST_SONG_SEL: begin
          has_event_o = 1'b1;
          event_o     = '{mbue_pkg::CIN_SYS_2BYTE, raw_r, midi_byte_i, 8'h00};
        end
        mbue_pkg::ST_SYSEX: begin
          case (ph)
            mbue_pkg::SX_START: begin
              hold0_nxt = midi_byte_i;
              phase_nxt = mbue_pkg::SX_START1;
            end
            mbue_pkg::SX_START1: begin
              first_nxt   = hold0_r;
              phase_nxt   = mbue_pkg::SX_HELD0;
              has_event_o = 1'b1;
              event_o     = '{mbue_pkg::CIN_SYSEX_CONT, raw_r, hold0_r, midi_byte_i};
            end
            mbue_pkg::SX_HELD1: begin
              hold1_nxt = midi_byte_i;
              phase_nxt = mbue_pkg::SX_HELD2;
            end
            mbue_pkg::SX_HELD2: begin
              hold2_nxt   = midi_byte_i;
              phase_nxt   = mbue_pkg::SX_HELD0;
              has_event_o = 1'b1;
              event_o     = '{mbue_pkg::CIN_SYSEX_CONT, hold0_r, hold1_r, midi_byte_i};
            end
            default: begin
              hold0_nxt = midi_byte_i;
              phase_nxt = mbue_pkg::SX_HELD1;
            end
          endcase
        end
        mbue_pkg::CH_NOTE_OFF, mbue_pkg::CH_NOTE_ON, mbue_pkg::CH_POLY_AT,
        mbue_pkg::CH_CTRL, mbue_pkg::CH_BEND, mbue_pkg::ST_SPP: begin
          await_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b0;
      run_r   <= '0;
      raw_r   <= '0;
      first_r <= '0;
      phase_r <= mbue_pkg::SX_HELD0;
      hold0_r <= '0;
      hold1_r <= '0;
      hold2_r <= '0;
    end else if (step_i) begin
      await_r <= await_nxt;
      run_r   <= run_nxt;
      raw_r   <= raw_nxt;
      first_r <= first_nxt;
      phase_r <= phase_nxt;
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
      hold2_r <= hold2_nxt;
    end
  end

endmodule

### sv/mbue_out_reg.sv
// Result register holding one event until the downstream side takes it.
module mbue_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load_i,
  input  mbue_pkg::event_t                    event_i,
  output logic                                free_o,   // can load this cycle
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbue_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic             valid_r, valid_nxt;
  mbue_pkg::event_t ev_r;

  assign free_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      ev_r <= event_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'h0, ev_r.event_byte2, ev_r.event_byte1,
                       ev_r.event_byte0, ev_r.code_index};

endmodule
